// ===== rtl/eevr_pkg.sv =====
// eevr_pkg: shared types, constants and CORDIC arctangent table for the
// ECEF/ENU vector rotation block. No dependencies.
`default_nettype none
package eevr_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 30;
    localparam int ATAN_ENTRIES      = 40;

    // angle in 1e-9 degree needs 39 bits plus sign
    localparam int ANG_W   = 40;
    localparam int TRIG_W  = 33;   // cordic x/y datapath
    localparam int Q_FRAC  = 30;

    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = 33'sd1073741824;
    localparam logic signed [ANG_W-1:0]  DEG90_N  = 40'sd90000000000;
    localparam logic signed [ANG_W-1:0]  DEG180_N = 40'sd180000000000;
    localparam logic signed [ANG_W-1:0]  DEG360_N = 40'sd360000000000;

    // configuration register indexes
    localparam logic [0:0] REG_LATITUDE  = 1'b0;
    localparam logic [0:0] REG_LONGITUDE = 1'b1;

    typedef logic signed [Q_FRAC+1:0] q30_t;   // sine/cosine, [-2^30, 2^30]

    // one cordic lane's state; the latitude and longitude lanes travel side by side
    typedef struct packed {
        logic signed [TRIG_W-1:0] x;
        logic signed [TRIG_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     neg;
    } cordic_lane_t;

    function automatic logic signed [ANG_W-1:0] atan_n(input int idx);
        logic signed [ANG_W-1:0] r;
        begin
            unique case (idx)
                0: r = 40'sd45000000000;  1: r = 40'sd26565051177;
                2: r = 40'sd14036243468;  3: r = 40'sd7125016349;
                4: r = 40'sd3576334375;   5: r = 40'sd1789910608;
                6: r = 40'sd895173710;    7: r = 40'sd447614171;
                8: r = 40'sd223810500;    9: r = 40'sd111905677;
                10: r = 40'sd55952892;    11: r = 40'sd27976453;
                12: r = 40'sd13988227;    13: r = 40'sd6994114;
                14: r = 40'sd3497057;     15: r = 40'sd1748528;
                16: r = 40'sd874264;      17: r = 40'sd437132;
                18: r = 40'sd218566;      19: r = 40'sd109283;
                20: r = 40'sd54642;       21: r = 40'sd27321;
                22: r = 40'sd13660;       23: r = 40'sd6830;
                24: r = 40'sd3415;        25: r = 40'sd1708;
                26: r = 40'sd854;         27: r = 40'sd427;
                28: r = 40'sd213;         29: r = 40'sd107;
                30: r = 40'sd53;          31: r = 40'sd27;
                32: r = 40'sd13;          33: r = 40'sd7;
                34: r = 40'sd3;           35: r = 40'sd2;
                36: r = 40'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ecef_enu_vector_rotation.sv =====
// ecef_enu_vector_rotation: top level; config registers, cordic cell chain,
// rotation stages and the output handshake. Uses eevr_pkg and submodules.
//
// Usage: write origin latitude (index 0) and longitude (index 1) on the
// cfg channel while idle. Each s_ transaction carries a vector and a
// direction in tuser; one m_ transaction returns the rotated vector with the
// saturation flag in tuser. The datapath is one pipeline: an angle prep
// cell, CORDIC_STAGES cordic cells, and five rotation stages. Throughput is
// one item per cycle while m_ is not stalled. The whole pipeline advances
// when the output register is empty or being taken, so a stalled receiver
// holds every stage in place and s_tready falls only while a result waits
// and m_tready is low. Reset clears the config registers to zero and
// empties the pipeline.
`default_nettype none
module ecef_enu_vector_rotation #(
    parameter int COORD_WIDTH   = eevr_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = eevr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // comp_x, comp_y, comp_z from bit 0 up
    input  wire logic [3*COORD_WIDTH-1:0] s_tdata,
    // direction
    input  wire logic                     s_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // out_x, out_y, out_z from bit 0 up
    output logic [3*COORD_WIDTH-1:0]      m_tdata,
    // saturated
    output logic                          m_tuser,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [31:0]              cfg_data
);
    import eevr_pkg::*;

    localparam int PIPE = CORDIC_STAGES + 1;   // prep plus cells

    logic [30:0] lat_reg;
    logic [31:0] lon_reg;
    logic        en;

    // config writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= '0;
            lon_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LATITUDE:  lat_reg <= cfg_data[30:0];
                REG_LONGITUDE: lon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // vector and valid delay line alongside the cordic chain
    logic [3*COORD_WIDTH-1:0] vd_reg [PIPE];
    logic                     dd_reg [PIPE];
    logic [PIPE-1:0]          vl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= '0;
        end else if (en) begin
            vl_reg <= {vl_reg[PIPE-2:0], s_tvalid};
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            vd_reg[0] <= s_tdata;
            dd_reg[0] <= s_tuser;
            for (int k = 1; k < PIPE; k++) begin
                vd_reg[k] <= vd_reg[k-1];
                dd_reg[k] <= dd_reg[k-1];
            end
        end
    end

    // cordic chain
    cordic_lane_t lat_l [PIPE];
    cordic_lane_t lon_l [PIPE];

    eevr_angle_prep u_prep_lat (
        .aclk(aclk), .en(en), .units({lat_reg[30], lat_reg}), .lane(lat_l[0]));
    eevr_angle_prep u_prep_lon (
        .aclk(aclk), .en(en), .units(lon_reg), .lane(lon_l[0]));

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        eevr_cordic_cell #(.STAGE(g)) u_cell (
            .aclk(aclk), .en(en),
            .lat_in(lat_l[g]), .lon_in(lon_l[g]),
            .lat_out(lat_l[g+1]), .lon_out(lon_l[g+1]));
    end

    logic signed [COORD_WIDTH-1:0] ox, oy, oz;
    logic sat, vout;

    eevr_rotate #(.COORD_WIDTH(COORD_WIDTH)) u_rot (
        .aclk(aclk), .en(en), .valid_in(vl_reg[PIPE-1]),
        .lat(lat_l[PIPE-1]), .lon(lon_l[PIPE-1]),
        .vx(vd_reg[PIPE-1][COORD_WIDTH-1:0]),
        .vy(vd_reg[PIPE-1][2*COORD_WIDTH-1:COORD_WIDTH]),
        .vz(vd_reg[PIPE-1][3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .dir(dd_reg[PIPE-1]),
        .ox(ox), .oy(oy), .oz(oz), .sat(sat), .valid_out(vout));

    // output valid; rotate's own valid line is not reset, so gate with a reset shadow
    logic [5:0] rst_cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rst_cnt_reg <= '0;
        end else if (en && rst_cnt_reg != 6'd6) begin
            rst_cnt_reg <= rst_cnt_reg + 6'd1;
        end
    end

    assign m_tvalid = vout && (rst_cnt_reg == 6'd6);
    assign m_tdata  = {oz, oy, ox};
    assign m_tuser  = sat;
endmodule
`default_nettype wire

// ===== rtl/eevr_angle_prep.sv =====
// eevr_angle_prep: scales a register angle to 1e-9 degree, wraps it and
// folds it into [-90, 90] degree as a cordic seed. Uses eevr_pkg.
`default_nettype none
module eevr_angle_prep (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [31:0]    units,
    output eevr_pkg::cordic_lane_t     lane
);
    import eevr_pkg::*;

    logic signed [ANG_W-1:0] a100, aw, af;
    logic                    neg;
    cordic_lane_t            lane_reg;

    // times 100 as shifts and adds, then one wrap and one fold
    always_comb begin
        a100 = (ANG_W'(units) <<< 6) + (ANG_W'(units) <<< 5) + (ANG_W'(units) <<< 2);
        if (a100 > DEG180_N)
            aw = a100 - DEG360_N;
        else if (a100 < -DEG180_N)
            aw = a100 + DEG360_N;
        else
            aw = a100;
        neg = 1'b0;
        if (aw > DEG90_N) begin
            af  = aw - DEG180_N;
            neg = 1'b1;
        end else if (aw < -DEG90_N) begin
            af  = aw + DEG180_N;
            neg = 1'b1;
        end else begin
            af = aw;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg.x   <= GAIN_Q30;
            lane_reg.y   <= '0;
            lane_reg.z   <= af;
            lane_reg.neg <= neg;
        end
    end

    assign lane = lane_reg;
endmodule
`default_nettype wire

// ===== rtl/eevr_cordic_cell.sv =====
// eevr_cordic_cell: one micro-rotation of the rotation-mode cordic for
// latitude and longitude lanes. Uses eevr_pkg.
`default_nettype none
module eevr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire eevr_pkg::cordic_lane_t lat_in,
    input  wire eevr_pkg::cordic_lane_t lon_in,
    output eevr_pkg::cordic_lane_t     lat_out,
    output eevr_pkg::cordic_lane_t     lon_out
);
    import eevr_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN_I = atan_n(STAGE);

    cordic_lane_t lat_reg, lon_reg;

    function automatic cordic_lane_t rot(input cordic_lane_t l);
        cordic_lane_t r;
        begin
            r = l;
            if (l.z >= 0) begin
                r.x = l.x - (l.y >>> STAGE);
                r.y = l.y + (l.x >>> STAGE);
                r.z = l.z - ATAN_I;
            end else begin
                r.x = l.x + (l.y >>> STAGE);
                r.y = l.y - (l.x >>> STAGE);
                r.z = l.z + ATAN_I;
            end
            return r;
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_reg <= rot(lat_in);
            lon_reg <= rot(lon_in);
        end
    end

    assign lat_out = lat_reg;
    assign lon_out = lon_reg;
endmodule
`default_nettype wire

// ===== rtl/eevr_rotate.sv =====
// eevr_rotate: builds the rotation matrix from sine/cosine, picks it or its
// transpose, and forms three rounded saturated dot products. Uses eevr_pkg.
`default_nettype none
module eevr_rotate #(
    parameter int COORD_WIDTH = eevr_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic                          valid_in,
    input  wire eevr_pkg::cordic_lane_t        lat,
    input  wire eevr_pkg::cordic_lane_t        lon,
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic signed [COORD_WIDTH-1:0] vz,
    input  wire logic                          dir,
    output logic signed [COORD_WIDTH-1:0]      ox,
    output logic signed [COORD_WIDTH-1:0]      oy,
    output logic signed [COORD_WIDTH-1:0]      oz,
    output logic                               sat,
    output logic                               valid_out
);
    import eevr_pkg::*;

    localparam int QW = Q_FRAC + 2;                 // 32-bit signed q30
    localparam int PW = QW + COORD_WIDTH;           // product width
    localparam int SW = PW + 2;                     // sum of three
    localparam int LAT = 5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    function automatic q30_t clampneg(input logic signed [TRIG_W-1:0] v,
                                      input logic n);
        q30_t c;
        begin
            if (v > ONE_Q30)       c = ONE_Q30[QW-1:0];
            else if (v < -ONE_Q30) c = -ONE_Q30[QW-1:0];
            else                   c = v[QW-1:0];
            return n ? -c : c;
        end
    endfunction

    // stage 1: clamp trig, align vector
    q30_t sp_reg, cp_reg, sl_reg, cl_reg;
    coord_t v1_reg [3];
    logic d1_reg;
    // stage 2: raw products of trig pairs
    logic signed [2*QW-1:0] p_reg [4];
    q30_t sp2_reg, cp2_reg, sl2_reg, cl2_reg;
    coord_t v2_reg [3];
    logic d2_reg;
    // stage 3: matrix, selected for direction
    q30_t m_reg [3][3];
    coord_t v3_reg [3];
    // stage 4: entry times component
    logic signed [PW-1:0] t_reg [3][3];
    // stage 5: output
    coord_t o_reg [3];
    logic sat_reg;
    logic [LAT-1:0] vld_reg;

    function automatic q30_t mulq(input logic signed [2*QW-1:0] p);
        logic signed [2*QW-1:0] r;
        begin
            r = (p + (2*QW)'(1 <<< (Q_FRAC-1))) >>> Q_FRAC;
            return r[QW-1:0];
        end
    endfunction

    q30_t r [3][3];
    always_comb begin
        r[0][0] = -sl2_reg;           r[0][1] = cl2_reg;           r[0][2] = '0;
        r[1][0] = -mulq(p_reg[0]);    r[1][1] = -mulq(p_reg[1]);   r[1][2] = cp2_reg;
        r[2][0] = mulq(p_reg[2]);     r[2][1] = mulq(p_reg[3]);    r[2][2] = sp2_reg;
    end

    // rounded sum and saturation for each row
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);
    logic signed [SW-1:0] s [3];
    coord_t o_next [3];
    logic sat_next;
    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s[i] = (SW'(t_reg[i][0]) + SW'(t_reg[i][1]) + SW'(t_reg[i][2])
                    + SW'(1 <<< (Q_FRAC-1))) >>> Q_FRAC;
            if (s[i] > HI) begin
                o_next[i] = HI[COORD_WIDTH-1:0];
                sat_next  = 1'b1;
            end else if (s[i] < LO) begin
                o_next[i] = LO[COORD_WIDTH-1:0];
                sat_next  = 1'b1;
            end else begin
                o_next[i] = s[i][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sp_reg <= clampneg(lat.y, lat.neg);
            cp_reg <= clampneg(lat.x, lat.neg);
            sl_reg <= clampneg(lon.y, lon.neg);
            cl_reg <= clampneg(lon.x, lon.neg);
            v1_reg[0] <= vx; v1_reg[1] <= vy; v1_reg[2] <= vz;
            d1_reg <= dir;

            p_reg[0] <= cl_reg * sp_reg;
            p_reg[1] <= sl_reg * sp_reg;
            p_reg[2] <= cl_reg * cp_reg;
            p_reg[3] <= sl_reg * cp_reg;
            sp2_reg <= sp_reg; cp2_reg <= cp_reg;
            sl2_reg <= sl_reg; cl2_reg <= cl_reg;
            v2_reg <= v1_reg;
            d2_reg <= d1_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m_reg[i][j] <= d2_reg ? r[j][i] : r[i][j];
            v3_reg <= v2_reg;

            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    t_reg[i][j] <= m_reg[i][j] * v3_reg[j];

            o_reg   <= o_next;
            sat_reg <= sat_next;
            vld_reg <= {vld_reg[LAT-2:0], valid_in};
        end
    end

    assign ox = o_reg[0];
    assign oy = o_reg[1];
    assign oz = o_reg[2];
    assign sat = sat_reg;
    assign valid_out = vld_reg[LAT-1];
endmodule
`default_nettype wire

// ===== rtl/eevr_checker.sv =====
// eevr_checker: port-level assertions for ecef_enu_vector_rotation and the
// bind that attaches them. Uses no package.
`default_nettype none
module eevr_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tready,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [3*COORD_WIDTH-1:0] m_tdata,
    input wire logic                     m_tuser,
    input wire logic                     cfg_ready
);
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // input side opens whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // stall freezes input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during stall");

    a_cfg: assert property (@(posedge aclk) cfg_ready)
        else $error("config port not ready");
endmodule

bind ecef_enu_vector_rotation eevr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .cfg_ready(cfg_ready));
`default_nettype wire
